// ===== src/two_stack_queue_top_defines.svh =====
// ----------------------------------------------------------------------------
// two_stack_queue_top_defines : assertion macros shared by the queue rtl
// ----------------------------------------------------------------------------
`ifndef TWO_STACK_QUEUE_TOP_DEFINES_SVH
`define TWO_STACK_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TSQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("two_stack_queue: implication failed");

// next-cycle implication, checked outside reset
`define TSQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two_stack_queue: next-cycle implication failed");

`endif

// ===== src/tsq_pkg.sv =====
// ----------------------------------------------------------------------------
// tsq_pkg
// shared types and status codes of the two stack queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsq_pkg;

    localparam int DATA_W = 32;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture the request
        logic push;      // enqueue onto inbound stack, result ok
        logic res_ovf;   // overflow result
        logic res_under; // underflow result
        logic xfer_rd;   // read inbound top, drop inbound count
        logic xfer_wr;   // write last read entry onto outbound stack
        logic pop_rd;    // read outbound top, drop outbound count
        logic res_pop;   // result from outbound read data
    } tsq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_deq;
        logic in_full;
        logic in_empty;
        logic out_empty;
    } tsq_sts_t;

endpackage

`default_nettype wire

// ===== src/tsq_ram.sv =====
// ----------------------------------------------------------------------------
// tsq_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/tsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsq_ctrl
// request sequencer: enqueue, dequeue, stack transfer and response strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "two_stack_queue_top_defines.svh"

module tsq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire tsq_pkg::tsq_sts_t sts,
    output logic                  busy,
    output logic                  done,
    output tsq_pkg::tsq_cmd_t     cmd
);
    import tsq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_XFER = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       pend_reg, pend_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!sts.is_deq)
                begin
                    if (sts.in_full)
                    begin
                        cmd.res_ovf = 1'b1;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!sts.out_empty)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_RESP;
                end
                else if (sts.in_empty)
                begin
                    cmd.res_under = 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_XFER;
                end
            end
            S_XFER:
            begin
                // read of one entry overlaps the write of the one before
                cmd.xfer_rd = !sts.in_empty;
                cmd.xfer_wr = pend_reg;
                pend_next   = !sts.in_empty;
                if (sts.in_empty && !pend_reg)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                cmd.res_pop = 1'b1;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `TSQ_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE)
    `TSQ_ASSERT_NEXT(a_accept_exec, clk, rst_n, start && !busy, state_reg == S_EXEC)
    `TSQ_ASSERT_NOW(a_resp_after_pop, clk, rst_n, state_reg == S_RESP, $past(cmd.pop_rd))

endmodule

`default_nettype wire

// ===== src/tsq_dp.sv =====
// ----------------------------------------------------------------------------
// tsq_dp
// datapath: two stack memories, their counts, request and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "two_stack_queue_top_defines.svh"

module tsq_dp #(
    parameter int DEPTH = 128
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        command,
    input  wire logic signed [tsq_pkg::DATA_W-1:0] data_in,
    input  wire tsq_pkg::tsq_cmd_t           cmd,
    output tsq_pkg::tsq_sts_t                sts,
    output logic signed [tsq_pkg::DATA_W-1:0] data_out,
    output logic [1:0]                       status
);
    import tsq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     in_cnt_reg, in_cnt_next;
    logic [CW-1:0]     out_cnt_reg, out_cnt_next;
    logic              deq_reg;
    logic [DATA_W-1:0] din_reg;
    logic [DATA_W-1:0] dout_reg;
    logic [1:0]        status_reg;
    logic [CW-1:0]     in_top, out_top;
    logic [DATA_W-1:0] in_rdata, out_rdata;

    assign in_top  = in_cnt_reg - CW'(1);
    assign out_top = out_cnt_reg - CW'(1);

    tsq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_in_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (in_cnt_reg[AW-1:0]),
        .wdata (din_reg),
        .raddr (in_top[AW-1:0]),
        .rdata (in_rdata)
    );

    tsq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_out_ram (
        .clk   (clk),
        .we    (cmd.xfer_wr),
        .waddr (out_cnt_reg[AW-1:0]),
        .wdata (in_rdata),
        .raddr (out_top[AW-1:0]),
        .rdata (out_rdata)
    );

    always_comb
    begin
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        if (cmd.push)
        begin
            in_cnt_next = in_cnt_reg + CW'(1);
        end
        else if (cmd.xfer_rd)
        begin
            in_cnt_next = in_top;
        end
        if (cmd.xfer_wr)
        begin
            out_cnt_next = out_cnt_reg + CW'(1);
        end
        else if (cmd.pop_rd)
        begin
            out_cnt_next = out_top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            deq_reg <= command;
            din_reg <= data_in;
        end
        if (cmd.push)
        begin
            dout_reg   <= '0;
            status_reg <= ST_OK;
        end
        else if (cmd.res_ovf)
        begin
            dout_reg   <= '0;
            status_reg <= ST_OVERFLOW;
        end
        else if (cmd.res_under)
        begin
            dout_reg   <= '1;
            status_reg <= ST_UNDERFLOW;
        end
        else if (cmd.res_pop)
        begin
            dout_reg   <= out_rdata;
            status_reg <= ST_OK;
        end
    end

    assign sts.is_deq    = (deq_reg == CMD_DEQ);
    assign sts.in_full   = (in_cnt_reg == CW'(DEPTH));
    assign sts.in_empty  = (in_cnt_reg == '0);
    assign sts.out_empty = (out_cnt_reg == '0);

    assign data_out = $signed(dout_reg);
    assign status   = status_reg;

    `TSQ_ASSERT_NOW(a_push_not_full, clk, rst_n, cmd.push, in_cnt_reg != CW'(DEPTH))
    `TSQ_ASSERT_NOW(a_xfer_room, clk, rst_n, cmd.xfer_wr, out_cnt_reg != CW'(DEPTH))
    `TSQ_ASSERT_NOW(a_pop_not_empty, clk, rst_n, cmd.pop_rd, out_cnt_reg != '0)

endmodule

`default_nettype wire

// ===== src/two_stack_queue_top.sv =====
// ----------------------------------------------------------------------------
// two_stack_queue_top
// first-in first-out queue built from an inbound and an outbound stack
// ----------------------------------------------------------------------------
// channel   handshake          payload              direction
// request   start / busy       command, data_in     in
// response  done (strobe)      data_out, status     out
//
// enqueue and underflow: request loaded on accept and settled in the execute
// state; done is registered and rises as the sequencer returns to idle
// dequeue from a non-empty outbound stack: pop read (registered ram read)
// dequeue needing a transfer: all inbound entries go to the outbound stack,
// one entry moved per cycle through the inbound ram read port
// reset clears both counts and the sequencer registers only; stack memories need no clearing pass
// done is a one-cycle strobe; the receiver cannot stall it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_stack_queue_top #(
    parameter int DEPTH = 128
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               command,
    input  wire logic signed [tsq_pkg::DATA_W-1:0]  data_in,
    output logic                                    done,
    output logic signed [tsq_pkg::DATA_W-1:0]       data_out,
    output logic [1:0]                              status
);
    import tsq_pkg::*;

    // command and status between sequencer and datapath
    tsq_cmd_t cmd;
    tsq_sts_t sts;

    // sequencer: accepts a request when idle, steps through push, pop
    // or the inbound-to-outbound transfer, or reports overflow or underflow, and strobes done
    tsq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // datapath: both stack memories, counts and the result registers,
    // which hold their value after the strobe
    tsq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .command  (command),
        .data_in  (data_in),
        .cmd      (cmd),
        .sts      (sts),
        .data_out (data_out),
        .status   (status)
    );

endmodule

`default_nettype wire
